// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the joint angle monitor. The checks
// compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define JAAM_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("invariant violated");

// The consequent must hold in the same cycle as the antecedent.
`define JAAM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

// The consequent must hold in the cycle after the antecedent.
`define JAAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`else

`define JAAM_ASSERT_ALWAYS(label, clk, rst_n, prop)
`define JAAM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define JAAM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/jaam_pkg.sv -----
// ----------------------------------------------------------------------------
// Joint angle monitor package
// Types, constants and register codes shared by the monitor modules.
// ----------------------------------------------------------------------------
package jaam_pkg;

    // Number of monitored joint axes, one lane each.
    localparam int NUM_AXES    = 3;
    localparam int AXIS_IDX_W  = $clog2(NUM_AXES);
    localparam int AXIS_W      = 2;
    localparam int ANGLE_W     = 16;
    localparam int ELAPSED_W   = 10;
    localparam int LEN_W       = 32;
    localparam int SETTLE_W    = 16;
    localparam int TIME_W      = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Saturation point of the time since the first sample.
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Length of the ready window after settling, in milliseconds.
    localparam logic [TIME_W-1:0] READY_WINDOW_MS = TIME_W'(1000);

    // Register values after reset.
    localparam logic signed [ANGLE_W-1:0] FLEX_LIMIT_RESET = ANGLE_W'(11520);
    localparam logic signed [ANGLE_W-1:0] ABD_LIMIT_RESET  = ANGLE_W'(5760);
    localparam logic signed [ANGLE_W-1:0] ROT_LIMIT_RESET  = ANGLE_W'(5760);
    localparam logic [SETTLE_W-1:0]       SETTLE_MS_RESET  = SETTLE_W'(5000);

    // Result item kinds.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EVENT  = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FLEX_LIMIT = 2'd0,
        REG_ABD_LIMIT  = 2'd1,
        REG_ROT_LIMIT  = 2'd2,
        REG_SETTLE_MS  = 2'd3
    } t_reg_idx;

    // Input sample.
    typedef struct packed {
        logic signed [ANGLE_W-1:0] flexion;
        logic signed [ANGLE_W-1:0] abduction;
        logic signed [ANGLE_W-1:0] rotation;
        logic [ELAPSED_W-1:0]      elapsed_ms;
        logic                      mute_press;
        logic                      unmute_press;
    } t_in_item;

    // Result item: a closed event record or the status item of a sample.
    typedef struct packed {
        logic                      kind;
        logic [AXIS_W-1:0]         axis;
        logic signed [ANGLE_W-1:0] peak_angle;
        logic [LEN_W-1:0]          duration_ms;
        logic                      alarm_active;
        logic                      buzzer_drive;
        logic                      ready_beep;
        logic                      settling;
        logic                      last;
    } t_out_item;

    // Event transitions that one lane found in a sample.
    typedef struct packed {
        logic opened;
        logic closed;
    } t_lane_flags;

    // Status of a sample after alarm and button handling.
    typedef struct packed {
        logic alarm;
        logic buzzer;
        logic ready;
        logic settling;
    } t_status;

endpackage

// ----- hdl/jaam_lane.sv -----
// ----------------------------------------------------------------------------
// Joint angle monitor lane
// Tracks the danger event of one axis: opens it, follows its peak and
// length, and reports the record when the angle falls back to the limit.
// ----------------------------------------------------------------------------
module jaam_lane (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic                                 i_check_en,
    input  logic signed [jaam_pkg::ANGLE_W-1:0]  i_angle,
    input  logic signed [jaam_pkg::ANGLE_W-1:0]  i_limit,
    input  logic [jaam_pkg::ELAPSED_W-1:0]       i_elapsed,
    output jaam_pkg::t_lane_flags                o_flags,
    output logic signed [jaam_pkg::ANGLE_W-1:0]  o_peak,
    output logic [jaam_pkg::LEN_W-1:0]           o_length,
    output logic                                 o_open
);

    logic                                r_open;
    logic                                n_open;
    logic signed [jaam_pkg::ANGLE_W-1:0] r_peak;
    logic signed [jaam_pkg::ANGLE_W-1:0] n_peak;
    logic [jaam_pkg::LEN_W-1:0]          r_length;
    logic [jaam_pkg::LEN_W-1:0]          n_length;
    logic [jaam_pkg::LEN_W:0]            w_len_sum;
    logic [jaam_pkg::LEN_W-1:0]          w_len_sat;
    logic                                w_above;

    // An open event keeps counting time, saturating at the top of its range.
    assign w_len_sum = {1'b0, r_length} + (jaam_pkg::LEN_W+1)'(i_elapsed);
    assign w_len_sat = w_len_sum[jaam_pkg::LEN_W] ? {jaam_pkg::LEN_W{1'b1}}
                                                  : w_len_sum[jaam_pkg::LEN_W-1:0];

    // Threshold check; only made once settling is over.
    assign w_above        = i_angle > i_limit;
    assign o_flags.opened = i_check_en && w_above && !r_open;
    assign o_flags.closed = i_check_en && !w_above && r_open;

    // Record of the event closed by this sample.
    assign o_peak   = r_peak;
    assign o_length = w_len_sat;
    assign o_open   = r_open;

    // Next event state.
    always_comb begin
        n_open   = r_open;
        n_peak   = r_peak;
        n_length = r_open ? w_len_sat : r_length;
        if (o_flags.opened) begin
            n_open   = 1'b1;
            n_peak   = i_angle;
            n_length = '0;
        end else if (o_flags.closed) begin
            n_open = 1'b0;
        end else if (i_check_en && w_above && (i_angle > r_peak)) begin
            n_peak = i_angle;
        end
    end

    // Event open flag is control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (i_accept) begin
            r_open <= n_open;
        end
    end

    // Peak and length are only read while the event is open.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_peak   <= n_peak;
            r_length <= n_length;
        end
    end

endmodule

// ----- hdl/jaam_merge.sv -----
// ----------------------------------------------------------------------------
// Joint angle monitor merge stage
// Keeps the settling clock, combines the lane transitions in axis order into
// the alarm latch and mute state, and forms the status of each sample.
// ----------------------------------------------------------------------------
module jaam_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [jaam_pkg::ELAPSED_W-1:0]      i_elapsed,
    input  logic                                i_mute,
    input  logic                                i_unmute,
    input  logic [jaam_pkg::SETTLE_W-1:0]       i_settle_ms,
    input  jaam_pkg::t_lane_flags               i_flags [jaam_pkg::NUM_AXES],
    input  logic [jaam_pkg::NUM_AXES-1:0]       i_open,
    output logic                                o_check_en,
    output jaam_pkg::t_status                   o_status,
    output logic                                o_alarm
);

    logic                          r_started;
    logic [jaam_pkg::TIME_W-1:0]   r_time;
    logic [jaam_pkg::TIME_W-1:0]   n_time;
    logic                          r_alarm;
    logic                          n_alarm;
    logic                          r_muted;
    logic                          n_muted;
    logic [jaam_pkg::TIME_W:0]     w_time_sum;
    logic [jaam_pkg::TIME_W-1:0]   w_settle;
    logic [jaam_pkg::TIME_W-1:0]   w_ready_end;
    logic                          w_settling;
    logic [jaam_pkg::NUM_AXES-1:0] w_open_vec;

    // Time since the first sample; the first sample restarts it at zero.
    assign w_time_sum = {1'b0, r_time} + (jaam_pkg::TIME_W+1)'(i_elapsed);
    always_comb begin
        if (!r_started) begin
            n_time = '0;
        end else if (w_time_sum > {1'b0, jaam_pkg::TIME_MAX}) begin
            n_time = jaam_pkg::TIME_MAX;
        end else begin
            n_time = w_time_sum[jaam_pkg::TIME_W-1:0];
        end
    end

    // Settling and ready window from the updated time.
    assign w_settle    = jaam_pkg::TIME_W'(i_settle_ms);
    assign w_ready_end = w_settle + jaam_pkg::READY_WINDOW_MS;
    assign w_settling  = n_time < w_settle;
    assign o_check_en  = !w_settling;

    // Walk the lanes in axis order: an opening sets the alarm, the last
    // closing clears it, and mute is cleared whenever the alarm changes.
    always_comb begin
        w_open_vec = i_open;
        n_alarm    = r_alarm;
        n_muted    = r_muted;
        for (int i = 0; i < jaam_pkg::NUM_AXES; i++) begin
            if (i_flags[i].opened) begin
                w_open_vec[i] = 1'b1;
                if (!n_alarm) begin
                    n_alarm = 1'b1;
                    n_muted = 1'b0;
                end
            end
            if (i_flags[i].closed) begin
                w_open_vec[i] = 1'b0;
                if (n_alarm && !(|w_open_vec)) begin
                    n_alarm = 1'b0;
                    n_muted = 1'b0;
                end
            end
        end
        // Buttons act after the angle checks; unmute wins.
        if (i_unmute) begin
            n_muted = 1'b0;
        end else if (i_mute) begin
            n_muted = 1'b1;
        end
    end

    // Status of the sample being accepted.
    assign o_status.alarm    = n_alarm;
    assign o_status.buzzer   = n_alarm && !n_muted;
    assign o_status.ready    = !w_settling && (n_time < w_ready_end);
    assign o_status.settling = w_settling;
    assign o_alarm           = r_alarm;

    // Sample-level state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_time    <= '0;
            r_alarm   <= 1'b0;
            r_muted   <= 1'b0;
        end else if (i_accept) begin
            r_started <= 1'b1;
            r_time    <= n_time;
            r_alarm   <= n_alarm;
            r_muted   <= n_muted;
        end
    end

endmodule

// ----- hdl/jaam_emit.sv -----
// ----------------------------------------------------------------------------
// Joint angle monitor result emitter
// Holds one sample's results and sends its closed event records in axis
// order, then its status item, through a registered output.
// ----------------------------------------------------------------------------
module jaam_emit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic [jaam_pkg::NUM_AXES-1:0]       i_mask,
    input  logic signed [jaam_pkg::ANGLE_W-1:0] i_peak [jaam_pkg::NUM_AXES],
    input  logic [jaam_pkg::LEN_W-1:0]          i_length [jaam_pkg::NUM_AXES],
    input  jaam_pkg::t_status                   i_status,
    output logic                                o_free,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output jaam_pkg::t_out_item                 o_out_data
);

    logic                                r_bvalid;
    logic [jaam_pkg::NUM_AXES-1:0]       r_mask;
    logic [jaam_pkg::NUM_AXES-1:0]       n_mask;
    logic signed [jaam_pkg::ANGLE_W-1:0] r_peak [jaam_pkg::NUM_AXES];
    logic [jaam_pkg::LEN_W-1:0]          r_length [jaam_pkg::NUM_AXES];
    jaam_pkg::t_status                   r_status;
    logic                                r_ovalid;
    jaam_pkg::t_out_item                 r_out;
    jaam_pkg::t_out_item                 n_out;
    logic [jaam_pkg::AXIS_IDX_W-1:0]     w_sel;
    logic                                w_found;
    logic                                w_take;
    logic                                w_done;

    // The output register takes a new item when empty or being drained.
    assign w_take = r_bvalid && (!r_ovalid || i_out_ready);
    assign w_done = w_take && !(|r_mask);
    assign o_free = !r_bvalid || w_done;

    // Lowest pending axis goes first.
    always_comb begin
        w_sel   = '0;
        w_found = 1'b0;
        for (int i = 0; i < jaam_pkg::NUM_AXES; i++) begin
            if (r_mask[i] && !w_found) begin
                w_sel   = jaam_pkg::AXIS_IDX_W'(i);
                w_found = 1'b1;
            end
        end
    end

    // Next output item: a record while any remain, then the status item.
    always_comb begin
        n_mask = r_mask;
        n_out  = '0;
        if (w_found) begin
            n_mask[w_sel]    = 1'b0;
            n_out.kind       = jaam_pkg::KIND_EVENT;
            n_out.axis       = jaam_pkg::AXIS_W'(w_sel);
            n_out.peak_angle = r_peak[w_sel];
            n_out.duration_ms = r_length[w_sel];
        end else begin
            n_out.kind         = jaam_pkg::KIND_STATUS;
            n_out.alarm_active = r_status.alarm;
            n_out.buzzer_drive = r_status.buzzer;
            n_out.ready_beep   = r_status.ready;
            n_out.settling     = r_status.settling;
            n_out.last         = 1'b1;
        end
    end

    // Sample buffer and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvalid <= 1'b0;
            r_mask   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_load) begin
                r_bvalid <= 1'b1;
                r_mask   <= i_mask;
            end else if (w_done) begin
                r_bvalid <= 1'b0;
            end else if (w_take) begin
                r_mask <= n_mask;
            end
            if (w_take) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_peak   <= i_peak;
            r_length <= i_length;
            r_status <= i_status;
        end
        if (w_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

// ----- hdl/joint_angle_event_alarm_monitor.sv -----
// ----------------------------------------------------------------------------
// Joint angle event alarm monitor
// Checks three joint angles per sample against their limits, reports each
// closed danger event, and drives the alarm, buzzer and ready indications.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the input channel (i_in_valid, o_in_ready, i_in_data).
// Each sample produces zero to three closed event records in axis order
// (flexion, abduction, rotation) followed by one status item with last set,
// on the output channel (o_out_valid, i_out_ready, o_out_data).
// Limits and settling time are written through the configuration channel,
// which is always ready.
// A sample is evaluated in the cycle it is accepted; its items pass through
// the emitter's sample buffer, then the output register. One result item
// leaves per cycle while the receiver is ready, so a sample with k closed
// events sends k + 1 items; the next sample is taken in the cycle its
// predecessor's status item moves to the output register: one sample per
// cycle without events and a ready receiver, later with closed events. The
// output register and the result emitter's one-sample buffer set this rate.
// Reset clears the settling clock, all events, alarm and mute, and loads the
// default limits. When the receiver stalls, the output register holds its
// item and the input channel stalls once the sample buffer is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module joint_angle_event_alarm_monitor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  jaam_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output jaam_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [jaam_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [jaam_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic signed [jaam_pkg::ANGLE_W-1:0] r_limit [jaam_pkg::NUM_AXES];
    logic [jaam_pkg::SETTLE_W-1:0]       r_settle_ms;
    logic signed [jaam_pkg::ANGLE_W-1:0] w_angle [jaam_pkg::NUM_AXES];
    jaam_pkg::t_lane_flags               w_flags [jaam_pkg::NUM_AXES];
    logic signed [jaam_pkg::ANGLE_W-1:0] w_peak [jaam_pkg::NUM_AXES];
    logic [jaam_pkg::LEN_W-1:0]          w_length [jaam_pkg::NUM_AXES];
    logic [jaam_pkg::NUM_AXES-1:0]       w_open;
    logic [jaam_pkg::NUM_AXES-1:0]       w_close_mask;
    jaam_pkg::t_status                   w_status;
    logic                                w_check_en;
    logic                                w_alarm;
    logic                                w_in_accept;

    // The configuration channel never stalls.
    assign o_cfg_ready = 1'b1;
    assign w_in_accept = i_in_valid && o_in_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit[0]  <= jaam_pkg::FLEX_LIMIT_RESET;
            r_limit[1]  <= jaam_pkg::ABD_LIMIT_RESET;
            r_limit[2]  <= jaam_pkg::ROT_LIMIT_RESET;
            r_settle_ms <= jaam_pkg::SETTLE_MS_RESET;
        end else if (i_cfg_valid) begin
            unique case (jaam_pkg::t_reg_idx'(i_cfg_index))
                jaam_pkg::REG_FLEX_LIMIT: r_limit[0]  <= i_cfg_data;
                jaam_pkg::REG_ABD_LIMIT:  r_limit[1]  <= i_cfg_data;
                jaam_pkg::REG_ROT_LIMIT:  r_limit[2]  <= i_cfg_data;
                jaam_pkg::REG_SETTLE_MS:  r_settle_ms <= i_cfg_data;
                default:                  r_settle_ms <= r_settle_ms;
            endcase
        end
    end

    // Angles of the sample in axis order.
    assign w_angle[0] = i_in_data.flexion;
    assign w_angle[1] = i_in_data.abduction;
    assign w_angle[2] = i_in_data.rotation;

    // One lane per axis.
    for (genvar g = 0; g < jaam_pkg::NUM_AXES; g++) begin : g_lane
        jaam_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_accept   (w_in_accept),
            .i_check_en (w_check_en),
            .i_angle    (w_angle[g]),
            .i_limit    (r_limit[g]),
            .i_elapsed  (i_in_data.elapsed_ms),
            .o_flags    (w_flags[g]),
            .o_peak     (w_peak[g]),
            .o_length   (w_length[g]),
            .o_open     (w_open[g])
        );
        assign w_close_mask[g] = w_flags[g].closed;
    end

    // Settling clock, alarm and mute.
    jaam_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_in_accept),
        .i_elapsed   (i_in_data.elapsed_ms),
        .i_mute      (i_in_data.mute_press),
        .i_unmute    (i_in_data.unmute_press),
        .i_settle_ms (r_settle_ms),
        .i_flags     (w_flags),
        .i_open      (w_open),
        .o_check_en  (w_check_en),
        .o_status    (w_status),
        .o_alarm     (w_alarm)
    );

    // Serializes records and status onto the output channel.
    jaam_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_in_accept),
        .i_mask      (w_close_mask),
        .i_peak      (w_peak),
        .i_length    (w_length),
        .i_status    (w_status),
        .o_free      (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // The alarm latch is on exactly while some axis has an open event.
    `JAAM_ASSERT_ALWAYS(a_alarm_tracks_events, i_clk, i_rst_n, w_alarm == (|w_open))

    // A sample taken while settling leaves the alarm unchanged.
    `JAAM_ASSERT_NEXT(a_settling_keeps_alarm, i_clk, i_rst_n, w_in_accept && w_status.settling, $stable(w_alarm))

    // A closed event record carries no status flags.
    `JAAM_ASSERT_IMPL(a_record_no_status, i_clk, i_rst_n, o_out_valid && o_out_data.kind, !o_out_data.last && !o_out_data.alarm_active && !o_out_data.settling)

endmodule

// ----- bench/joint_angle_event_alarm_monitor_tb.sv -----
// ----------------------------------------------------------------------------
// Joint angle event alarm monitor testbench
// Drives samples through the monitor with random source idles and random
// receiver back-pressure, and checks every result item against a cycle-free model of the
// settling clock, the per-axis danger events, the alarm latch and the mute
// buttons. Limits and settling time are reloaded between phases while the
// monitor is idle, covering the threshold extremes.
// ----------------------------------------------------------------------------
module joint_angle_event_alarm_monitor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   CLK_PERIOD  = 12;
    localparam int   QUIET_LIMIT = 3000;
    localparam int   ANGLE_SPAN  = 23040;
    localparam int   SETTLE_TOP  = 60000;

    // Tracks the monitor state and the result items still owed by it.
    class alarm_monitor_scoreboard;
        logic signed [jaam_pkg::ANGLE_W-1:0] limit_q [jaam_pkg::NUM_AXES];
        logic [jaam_pkg::SETTLE_W-1:0]       settle_q;
        bit                                  started_q;
        int unsigned                         clock_ms;
        bit                                  open_q [jaam_pkg::NUM_AXES];
        logic signed [jaam_pkg::ANGLE_W-1:0] peak_q [jaam_pkg::NUM_AXES];
        logic [jaam_pkg::LEN_W-1:0]          length_q [jaam_pkg::NUM_AXES];
        bit                                  alarm_q;
        bit                                  muted_q;
        jaam_pkg::t_out_item                 owed_items [$];
        int                                  mismatch_count;
        int                                  items_checked;

        function new();
            limit_q[0]     = jaam_pkg::FLEX_LIMIT_RESET;
            limit_q[1]     = jaam_pkg::ABD_LIMIT_RESET;
            limit_q[2]     = jaam_pkg::ROT_LIMIT_RESET;
            settle_q       = jaam_pkg::SETTLE_MS_RESET;
            started_q      = 1'b0;
            clock_ms       = 0;
            alarm_q        = 1'b0;
            muted_q        = 1'b0;
            mismatch_count = 0;
            items_checked  = 0;
            foreach (open_q[i]) begin
                open_q[i]   = 1'b0;
                peak_q[i]   = '0;
                length_q[i] = '0;
            end
        endfunction

        function void set_register(jaam_pkg::t_reg_idx idx,
                                   logic [jaam_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                jaam_pkg::REG_FLEX_LIMIT: limit_q[0] = value;
                jaam_pkg::REG_ABD_LIMIT:  limit_q[1] = value;
                jaam_pkg::REG_ROT_LIMIT:  limit_q[2] = value;
                jaam_pkg::REG_SETTLE_MS:  settle_q   = value;
                default: ;
            endcase
        endfunction

        // Appends one result item to the tail of the owed list.
        function void owe_item(jaam_pkg::t_out_item item);
            owed_items.insert(owed_items.size(), item);
        endfunction

        // Works out the closed event records and the status item of one sample.
        function void note_sample(jaam_pkg::t_in_item s);
            logic signed [jaam_pkg::ANGLE_W-1:0] angle [jaam_pkg::NUM_AXES];
            logic [jaam_pkg::LEN_W:0]            grown;
            jaam_pkg::t_out_item                 rec;
            bit                                  settling;
            bit                                  ready;
            bit                                  any_open;
            angle[0] = s.flexion;
            angle[1] = s.abduction;
            angle[2] = s.rotation;
            settling = 1'b0;
            ready    = 1'b0;

            // The first sample starts the clock; its gap does not count.
            if (!started_q) begin
                started_q = 1'b1;
                clock_ms  = 0;
            end else begin
                clock_ms += s.elapsed_ms;
                if (clock_ms > jaam_pkg::TIME_MAX)
                    clock_ms = jaam_pkg::TIME_MAX;
            end

            // Open events age on every sample, settling or not.
            for (int i = 0; i < jaam_pkg::NUM_AXES; i++) begin
                if (open_q[i]) begin
                    grown       = {1'b0, length_q[i]} + s.elapsed_ms;
                    length_q[i] = grown[jaam_pkg::LEN_W] ? '1
                                                         : grown[jaam_pkg::LEN_W-1:0];
                end
            end

            if (clock_ms < settle_q) begin
                settling = 1'b1;
            end else begin
                ready = clock_ms < settle_q + jaam_pkg::READY_WINDOW_MS;
                for (int i = 0; i < jaam_pkg::NUM_AXES; i++) begin
                    if (angle[i] > limit_q[i]) begin
                        if (!open_q[i]) begin
                            open_q[i]   = 1'b1;
                            peak_q[i]   = angle[i];
                            length_q[i] = '0;
                            if (!alarm_q) begin
                                alarm_q = 1'b1;
                                muted_q = 1'b0;
                            end
                        end else if (angle[i] > peak_q[i]) begin
                            peak_q[i] = angle[i];
                        end
                    end else if (open_q[i]) begin
                        open_q[i]       = 1'b0;
                        rec             = '0;
                        rec.kind        = jaam_pkg::KIND_EVENT;
                        rec.axis        = jaam_pkg::AXIS_W'(i);
                        rec.peak_angle  = peak_q[i];
                        rec.duration_ms = length_q[i];
                        owe_item(rec);
                        any_open = 1'b0;
                        foreach (open_q[k])
                            if (open_q[k])
                                any_open = 1'b1;
                        if (alarm_q && !any_open) begin
                            alarm_q = 1'b0;
                            muted_q = 1'b0;
                        end
                    end
                end
            end

            // Buttons act after the angle checks; unmute wins.
            if (s.unmute_press)
                muted_q = 1'b0;
            else if (s.mute_press)
                muted_q = 1'b1;

            rec              = '0;
            rec.kind         = jaam_pkg::KIND_STATUS;
            rec.alarm_active = alarm_q;
            rec.buzzer_drive = alarm_q && !muted_q;
            rec.ready_beep   = ready;
            rec.settling     = settling;
            rec.last         = 1'b1;
            owe_item(rec);
        endfunction

        task report_mismatch(string msg);
            if (mismatch_count < 200)
                $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task compare_field(string field, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                          items_checked, field, got, want));
        endtask

        task check_item(jaam_pkg::t_out_item got);
            jaam_pkg::t_out_item want;
            if (owed_items.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing owed",
                                          items_checked));
                items_checked++;
                return;
            end
            want = owed_items.pop_front();
            compare_field("kind",         got.kind,         want.kind);
            compare_field("axis",         got.axis,         want.axis);
            compare_field("peak_angle",   got.peak_angle,   want.peak_angle);
            compare_field("duration_ms",  got.duration_ms,  want.duration_ms);
            compare_field("alarm_active", got.alarm_active, want.alarm_active);
            compare_field("buzzer_drive", got.buzzer_drive, want.buzzer_drive);
            compare_field("ready_beep",   got.ready_beep,   want.ready_beep);
            compare_field("settling",     got.settling,     want.settling);
            compare_field("last",         got.last,         want.last);
            items_checked++;
        endtask
    endclass

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_ready;
    jaam_pkg::t_in_item              i_in_data   = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    jaam_pkg::t_out_item             o_out_data;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [jaam_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [jaam_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    alarm_monitor_scoreboard board;
    int src_idle_pct   = 0;
    int rx_idle_pct    = 0;
    int rx_hold_cycles = 0;
    int quiet_cycles   = 0;

    joint_angle_event_alarm_monitor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Result side readiness: a long hold-off when asked, else random stalls.
    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            rx_hold_cycles--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Every result transaction is checked against the oldest owed item.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_item(o_out_data);
    end

    // Ends the run when no transaction moves on any channel for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("joint_angle_event_alarm_monitor regression: fail");
                $finish;
            end
        end
    end

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic jaam_pkg::t_in_item make_sample(int flex, int abd, int rot,
                                                       int gap, bit mute,
                                                       bit unmute);
        jaam_pkg::t_in_item s;
        s.flexion      = jaam_pkg::ANGLE_W'(flex);
        s.abduction    = jaam_pkg::ANGLE_W'(abd);
        s.rotation     = jaam_pkg::ANGLE_W'(rot);
        s.elapsed_ms   = jaam_pkg::ELAPSED_W'(gap);
        s.mute_press   = mute;
        s.unmute_press = unmute;
        return s;
    endfunction

    // Angles cluster around the limit so that events open and close often.
    function automatic int pick_angle(logic signed [jaam_pkg::ANGLE_W-1:0] lim);
        int v;
        int roll;
        roll = $urandom_range(99);
        if (roll < 45)
            v = int'(lim) + rand_between(-600, 600);
        else if (roll < 85)
            v = rand_between(-ANGLE_SPAN, ANGLE_SPAN);
        else if (roll < 93)
            v = $urandom_range(1) ? ANGLE_SPAN : -ANGLE_SPAN;
        else
            v = int'(lim);
        if (v > ANGLE_SPAN)
            v = ANGLE_SPAN;
        else if (v < -ANGLE_SPAN)
            v = -ANGLE_SPAN;
        return v;
    endfunction

    function automatic jaam_pkg::t_in_item random_sample(bit long_gaps);
        int ang [jaam_pkg::NUM_AXES];
        int roll;
        int gap;
        roll = $urandom_range(99);
        for (int i = 0; i < jaam_pkg::NUM_AXES; i++) begin
            if (roll < 6)
                ang[i] = -ANGLE_SPAN;
            else if (roll < 12)
                ang[i] = ANGLE_SPAN;
            else
                ang[i] = pick_angle(board.limit_q[i]);
        end
        roll = $urandom_range(99);
        if (long_gaps)
            gap = ($urandom_range(9) == 0) ? 1023 : rand_between(500, 1023);
        else if (roll < 70)
            gap = rand_between(0, 40);
        else if (roll < 90)
            gap = rand_between(41, 300);
        else
            gap = rand_between(301, 1023);
        return make_sample(ang[0], ang[1], ang[2], gap,
                           $urandom_range(99) < 20, $urandom_range(99) < 15);
    endfunction

    // One sample transaction, with random idle cycles ahead of it.
    task automatic send_sample(jaam_pkg::t_in_item s);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_sample(s);
        @(negedge i_clk);
    endtask

    // Leaves the valid high so that back-to-back writes need no gap.
    task automatic write_register(jaam_pkg::t_reg_idx idx, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= jaam_pkg::CFG_DATA_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_register(idx, jaam_pkg::CFG_DATA_W'(value));
        @(negedge i_clk);
    endtask

    task automatic load_settings(int flex_lim, int abd_lim, int rot_lim, int settle);
        write_register(jaam_pkg::REG_FLEX_LIMIT, flex_lim);
        write_register(jaam_pkg::REG_ABD_LIMIT, abd_lim);
        write_register(jaam_pkg::REG_ROT_LIMIT, rot_lim);
        write_register(jaam_pkg::REG_SETTLE_MS, settle);
        i_cfg_valid <= 1'b0;
    endtask

    // Stops offering samples until every owed result has been taken.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (board.owed_items.size() != 0);
    endtask

    task automatic run_random(int count, bit long_gaps, int pause_at);
        for (int n = 0; n < count; n++) begin
            if (n == pause_at)
                drain_results();
            send_sample(random_sample(long_gaps));
        end
        drain_results();
    endtask

    initial begin
        board = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: the first sample, settling, the ready window, and
        // events opening, peaking and closing on one, two and three axes.
        src_idle_pct = 27;
        rx_idle_pct  = 84;
        send_sample(make_sample( 23040,  23040,  23040, 1023, 0, 0));
        send_sample(make_sample(-23040, -23040, -23040, 1023, 1, 0));
        send_sample(make_sample( 23040, -23040,   5761, 1023, 1, 1));
        send_sample(make_sample(     0,      0,      0, 1023, 0, 1));
        send_sample(make_sample(     0,      0,      0, 1023, 1, 0));
        send_sample(make_sample( 11520,   5760,   5760,  907, 0, 0));
        send_sample(make_sample( 11521,   5760,     -1,    1, 1, 0));
        send_sample(make_sample( 23040,   5761,      0,    0, 0, 0));
        send_sample(make_sample( 12000,  23040,  23040,   10, 0, 1));
        send_sample(make_sample( 11520,   6000,   5761,   20, 0, 0));
        send_sample(make_sample(-23040, -23040, -23040,   25, 1, 0));
        send_sample(make_sample( 23040,  23040,  23040,  100, 0, 0));
        send_sample(make_sample( 23040,  23040,  23040, 1023, 0, 0));
        send_sample(make_sample(-23040, -23040, -23040,  500, 0, 0));
        send_sample(make_sample(     0, -23040,  23040,    0, 1, 0));
        send_sample(make_sample(     0, -23040,  23040, 1023, 0, 0));
        send_sample(make_sample(     0,      0,      0,    3, 0, 0));
        send_sample(make_sample(     0,      0,      0,    0, 1, 1));
        drain_results();

        // Flexion limit at the bottom, abduction at the top, no settling.
        load_settings(-ANGLE_SPAN, ANGLE_SPAN, rand_between(-3000, 3000), 0);
        run_random(50, 1'b0, -1);

        // Settling again while events stay open, with the other extremes.
        src_idle_pct = 84;
        rx_idle_pct  = 27;
        load_settings(ANGLE_SPAN, -ANGLE_SPAN, -ANGLE_SPAN,
                      (board.clock_ms + 400 > SETTLE_TOP) ? SETTLE_TOP
                                                          : board.clock_ms + 400);
        run_random(50, 1'b0, -1);

        // The bench's top settling time, crossed with long gaps between samples.
        load_settings(rand_between(-6000, 12000), rand_between(-6000, 12000),
                      rand_between(-6000, 12000), SETTLE_TOP);
        run_random(60, 1'b1, -1);

        // Reset values again; the result side holds off so the input stalls.
        src_idle_pct = 0;
        rx_idle_pct  = 0;
        load_settings(jaam_pkg::FLEX_LIMIT_RESET, jaam_pkg::ABD_LIMIT_RESET,
                      jaam_pkg::ROT_LIMIT_RESET, jaam_pkg::SETTLE_MS_RESET);
        rx_hold_cycles = 300;
        run_random(80, 1'b0, -1);

        // Long gaps drive the sample clock into saturation.
        load_settings(rand_between(-ANGLE_SPAN, ANGLE_SPAN),
                      rand_between(-ANGLE_SPAN, ANGLE_SPAN),
                      rand_between(-ANGLE_SPAN, ANGLE_SPAN),
                      rand_between(0, SETTLE_TOP));
        run_random(70, 1'b1, 35);

        repeat (16) @(negedge i_clk);
        if (board.mismatch_count == 0)
            $display("joint_angle_event_alarm_monitor regression: pass");
        else
            $display("joint_angle_event_alarm_monitor regression: fail");
        $finish;
    end

endmodule
